>>> sv/etp_pkg.sv
`timescale 1ns / 1ps

package etp_pkg;

    // value arithmetic wraps at this width
    localparam int VALUE_BITS = 32;
    // consumed character count saturates here
    localparam int COUNT_MAX  = 255;
    localparam int COUNT_W    = $clog2(COUNT_MAX + 1);
    localparam int FRAC_W     = 20;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_W-1:0]    t_count;

    localparam t_value SCALE_TEN  = t_value'(10);
    localparam t_value SCALE_KILO = t_value'(1000);
    localparam t_value SCALE_MEGA = t_value'(1000000);
    localparam t_count COUNT_LIM  = t_count'(COUNT_MAX);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ZERO,
        MODE_DEC,
        MODE_HEXPFX,
        MODE_HEX,
        MODE_FRAC
    } t_mode;

    typedef struct packed {
        logic [7:0] char_in;
        logic       begin_token;
    } t_char_req;

    typedef struct packed {
        logic [31:0] number;
        logic        parse_ok;
        logic [7:0]  chars_used;
    } t_num_rsp;

    typedef struct packed {
        logic     valid;
        t_num_rsp rsp;
    } t_core_res;

endpackage

>>> sv/etp_in_reg.sv
`timescale 1ns / 1ps

module etp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  etp_pkg::t_char_req i_in_req,
    input  logic              i_take,
    output logic              o_item_valid,
    output etp_pkg::t_char_req o_item
);

    logic               r_valid;
    logic               n_valid;
    etp_pkg::t_char_req r_item;

    // hold a request only while the core cannot take it
    assign o_in_stall = r_valid & ~i_take;
    assign n_valid    = o_in_stall | i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item <= i_in_req;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> sv/etp_core.sv
`timescale 1ns / 1ps

module etp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  etp_pkg::t_char_req i_item,
    output etp_pkg::t_core_res o_res
);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_K     = 8'h6b;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] HEX_BIAS = 8'h57;

    // weight of the next fraction digit, highest decade first
    function automatic logic [etp_pkg::FRAC_W-1:0] frac_place(
        input logic       mega,
        input logic [2:0] digits
    );
        logic [etp_pkg::FRAC_W-1:0] place;
        place = '0;
        case ({mega, digits})
            4'b0000: place = 20'd100;
            4'b0001: place = 20'd10;
            4'b0010: place = 20'd1;
            4'b1000: place = 20'd100000;
            4'b1001: place = 20'd10000;
            4'b1010: place = 20'd1000;
            4'b1011: place = 20'd100;
            4'b1100: place = 20'd10;
            4'b1101: place = 20'd1;
            default: place = '0;
        endcase
        return place;
    endfunction

    etp_pkg::t_mode             r_mode;
    etp_pkg::t_mode             n_mode;
    etp_pkg::t_value            r_whole;
    etp_pkg::t_value            n_whole;
    logic [etp_pkg::FRAC_W-1:0] r_frac;
    logic [etp_pkg::FRAC_W-1:0] n_frac;
    logic [2:0]                 r_digits;
    logic [2:0]                 n_digits;
    logic                       r_mega;
    logic                       n_mega;
    etp_pkg::t_count            r_count;
    etp_pkg::t_count            n_count;

    logic [7:0] w_c;
    logic [7:0] w_lc;
    logic       w_begin;
    logic       w_is_dec;
    logic       w_is_zero;
    logic       w_is_hex;
    logic       w_is_xh;
    logic       w_is_km;
    logic [3:0] w_dec_d;
    logic [3:0] w_hex_d;
    logic       w_frac_room;
    etp_pkg::t_count            w_bump;
    etp_pkg::t_value            w_mul_ten;
    etp_pkg::t_value            w_mul_scale;
    logic [etp_pkg::FRAC_W-1:0] w_frac_add;
    etp_pkg::t_value            w_frac_sum;

    assign w_c       = i_item.char_in;
    assign w_begin   = i_item.begin_token;
    assign w_lc      = (w_c >= CH_UP_A && w_c <= CH_UP_Z) ? (w_c | CASE_BIT) : w_c;
    assign w_is_dec  = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_is_zero = (w_c == CH_ZERO);
    assign w_is_hex  = w_is_dec || ((w_lc >= CH_A) && (w_lc <= CH_F));
    assign w_is_xh   = (w_lc == CH_X) || (w_lc == CH_H);
    assign w_is_km   = (w_lc == CH_K) || (w_lc == CH_M);
    assign w_dec_d   = 4'(w_c - CH_ZERO);
    assign w_hex_d   = w_is_dec ? w_dec_d : 4'(w_lc - HEX_BIAS);

    assign w_frac_room = r_digits < (r_mega ? 3'd6 : 3'd3);
    assign w_bump      = (r_count < etp_pkg::COUNT_LIM) ? r_count + 1'b1 : r_count;
    assign w_mul_ten   = etp_pkg::t_value'(r_whole * etp_pkg::SCALE_TEN)
                       + etp_pkg::t_value'(w_dec_d);
    assign w_mul_scale = etp_pkg::t_value'(r_whole *
                         ((w_lc == CH_M) ? etp_pkg::SCALE_MEGA : etp_pkg::SCALE_KILO));
    assign w_frac_add  = etp_pkg::FRAC_W'(frac_place(r_mega, r_digits) * w_dec_d);
    // fraction is kept already scaled, so the missing decades are zero
    assign w_frac_sum  = r_whole + etp_pkg::t_value'(r_frac);

    // next state
    always_comb begin
        n_mode = r_mode;
        if (w_begin) begin
            if (w_is_zero) begin
                n_mode = etp_pkg::MODE_ZERO;
            end else if (w_is_xh) begin
                n_mode = etp_pkg::MODE_HEXPFX;
            end else if (w_is_dec) begin
                n_mode = etp_pkg::MODE_DEC;
            end else begin
                n_mode = etp_pkg::MODE_IDLE;
            end
        end else begin
            case (r_mode)
                etp_pkg::MODE_ZERO, etp_pkg::MODE_DEC: begin
                    if (r_mode == etp_pkg::MODE_ZERO && w_is_xh) begin
                        n_mode = etp_pkg::MODE_HEXPFX;
                    end else if (w_is_dec) begin
                        n_mode = etp_pkg::MODE_DEC;
                    end else if (w_is_km) begin
                        n_mode = etp_pkg::MODE_FRAC;
                    end else begin
                        n_mode = etp_pkg::MODE_IDLE;
                    end
                end
                etp_pkg::MODE_FRAC: begin
                    n_mode = w_is_dec ? etp_pkg::MODE_FRAC : etp_pkg::MODE_IDLE;
                end
                etp_pkg::MODE_HEXPFX, etp_pkg::MODE_HEX: begin
                    n_mode = w_is_hex ? etp_pkg::MODE_HEX : etp_pkg::MODE_IDLE;
                end
                default: n_mode = etp_pkg::MODE_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_whole  = r_whole;
        n_frac   = r_frac;
        n_digits = r_digits;
        n_mega   = r_mega;
        n_count  = r_count;
        o_res    = '0;
        if (w_begin) begin
            n_frac   = '0;
            n_digits = '0;
            n_mega   = 1'b0;
            n_whole  = '0;
            if (w_is_dec || w_is_xh) begin
                n_count = etp_pkg::t_count'(1);
                if (w_is_dec) begin
                    n_whole = etp_pkg::t_value'(w_dec_d);
                end
            end else begin
                n_count   = '0;
                o_res.valid = 1'b1;
            end
        end else begin
            case (r_mode)
                etp_pkg::MODE_ZERO, etp_pkg::MODE_DEC: begin
                    if (r_mode == etp_pkg::MODE_ZERO && w_is_xh) begin
                        n_count = w_bump;
                    end else if (w_is_dec) begin
                        n_whole = w_mul_ten;
                        n_count = w_bump;
                    end else if (w_is_km) begin
                        n_mega   = (w_lc == CH_M);
                        n_whole  = w_mul_scale;
                        n_frac   = '0;
                        n_digits = '0;
                        n_count  = w_bump;
                    end else begin
                        o_res.valid        = 1'b1;
                        o_res.rsp.number   = 32'(r_whole);
                        o_res.rsp.parse_ok = 1'b1;
                        o_res.rsp.chars_used = 8'(r_count);
                    end
                end
                etp_pkg::MODE_FRAC: begin
                    if (w_is_dec) begin
                        if (w_frac_room) begin
                            n_frac   = r_frac + w_frac_add;
                            n_digits = r_digits + 3'd1;
                        end
                        n_count = w_bump;
                    end else begin
                        o_res.valid        = 1'b1;
                        o_res.rsp.number   = 32'(w_frac_sum);
                        o_res.rsp.parse_ok = 1'b1;
                        o_res.rsp.chars_used = 8'(r_count);
                    end
                end
                etp_pkg::MODE_HEXPFX: begin
                    if (w_is_hex) begin
                        n_whole = etp_pkg::t_value'(w_hex_d);
                        n_count = w_bump;
                    end else begin
                        o_res.valid          = 1'b1;
                        o_res.rsp.chars_used = 8'(r_count);
                    end
                end
                etp_pkg::MODE_HEX: begin
                    if (w_is_hex) begin
                        n_whole = {r_whole[etp_pkg::VALUE_BITS-5:0], w_hex_d};
                        n_count = w_bump;
                    end else begin
                        o_res.valid        = 1'b1;
                        o_res.rsp.number   = 32'(r_whole);
                        o_res.rsp.parse_ok = 1'b1;
                        o_res.rsp.chars_used = 8'(r_count);
                    end
                end
                default: begin
                    n_whole = r_whole;
                end
            endcase
        end
        if (!i_step) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= etp_pkg::MODE_IDLE;
        end else if (i_step) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_whole  <= n_whole;
            r_frac   <= n_frac;
            r_digits <= n_digits;
            r_mega   <= n_mega;
            r_count  <= n_count;
        end
    end

endmodule

>>> sv/etp_out_reg.sv
`timescale 1ns / 1ps

module etp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etp_pkg::t_core_res i_res,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output etp_pkg::t_num_rsp  o_out_rsp
);

    logic              r_valid;
    logic              n_valid;
    etp_pkg::t_num_rsp r_rsp;

    // free, or being drained at this edge
    assign o_ready = ~r_valid | ~i_out_stall;
    assign n_valid = o_ready ? i_res.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res.valid) begin
            r_rsp <= i_res.rsp;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_rsp   = r_rsp;

endmodule

>>> sv/engineering_uint_text_parser_unit.sv
`timescale 1ns / 1ps

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------
// in       | input     | i_in_valid / o_in_stall | i_in_req  (char_in, begin_token)
// out      | output    | o_out_valid/ i_out_stall| o_out_rsp (number, parse_ok,
//          |           |                         |            chars_used)
//
// one character per cycle while o_in_stall is low; a request is registered in
// the input register, then the parse step and its result register take it
// once the output register is ready, and the result leaves from that register
// i_rst_n is synchronous, active low, and returns the parser to no open token
// an output stall holds the result register and, once the input register is
// full too, raises o_in_stall in the same cycle

module engineering_uint_text_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  etp_pkg::t_char_req i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output etp_pkg::t_num_rsp  o_out_rsp
);

    logic               w_item_valid;
    etp_pkg::t_char_req w_item;
    logic               w_out_ready;
    logic               w_step;
    etp_pkg::t_core_res w_res;

    assign w_step = w_item_valid & w_out_ready;

    etp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_take       (w_out_ready),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    etp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (w_item),
        .o_res   (w_res)
    );

    etp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .o_ready     (w_out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

`ifndef SYNTHESIS
    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.parse_ok) |-> (o_out_rsp.number == 32'd0))
        else $error("failed parse carries a nonzero number");

    a_ok_has_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.parse_ok) |-> (o_out_rsp.chars_used != 8'd0))
        else $error("successful parse with no characters used");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_item_valid && !w_out_ready))
        else $error("input stalled without a blocked request");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.valid) |=> o_out_valid)
        else $error("result lost after a parse step");
`endif

endmodule
